@@ rtl/mht_pkg.sv @@
// ----------------------------------------------------------------------------
// Mnemonic hash table package
// Shared widths, status and request codes, and the slot record type.
// ----------------------------------------------------------------------------
package mht_pkg;

   localparam int TABLE_SIZE_DEF = 256;

   localparam int CHAR_W   = 7;
   localparam int KEY_W    = 3 * CHAR_W;
   localparam int VALUE_W  = 8;
   localparam int STATUS_W = 2;
   localparam int SUM_W    = CHAR_W + 6;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY_NAME = 2'd3;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } slot_type;

endpackage

@@ rtl/mht_modred.sv @@
// ----------------------------------------------------------------------------
// Mnemonic hash table modulo unit
// Reduces the hash sum modulo the table size by a reciprocal multiply and one
// corrective subtract, each step registered: product, remainder, result.
// ----------------------------------------------------------------------------
module mht_modred #(
   parameter int TABLE_SIZE = mht_pkg::TABLE_SIZE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [mht_pkg::SUM_W-1:0]      sum_in,
   output logic                           done,
   output logic [$clog2(TABLE_SIZE)-1:0]  result
);
   import mht_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_SIZE);
   localparam int PROD_W = 2 * SUM_W;
   localparam logic [SUM_W-1:0] DIVISOR = SUM_W'(TABLE_SIZE);
   localparam logic [SUM_W-1:0] RECIP   = SUM_W'((1 << SUM_W) / TABLE_SIZE);

   logic [SUM_W-1:0]  hold_ff, hold_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [IDX_W-1:0]  res_ff, res_in;
   logic              ph1_ff, ph1_in;
   logic              ph2_ff, ph2_in;
   logic              done_ff, done_in;

   logic [SUM_W-1:0]  quot;
   logic [PROD_W-1:0] back_prod;

   always_comb begin
      hold_in   = hold_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      res_in    = res_ff;
      ph1_in    = start;
      ph2_in    = ph1_ff;
      done_in   = ph2_ff;
      quot      = prod_ff[PROD_W-1:SUM_W];
      back_prod = PROD_W'(quot) * PROD_W'(DIVISOR);
      if (start) begin
         hold_in = sum_in;
         prod_in = PROD_W'(sum_in) * PROD_W'(RECIP);
      end
      if (ph1_ff) begin
         rem_in = hold_ff - back_prod[SUM_W-1:0];
      end
      if (ph2_ff) begin
         res_in = (rem_ff >= DIVISOR) ? IDX_W'(rem_ff - DIVISOR) : rem_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph1_ff  <= 1'b0;
         ph2_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         ph1_ff  <= ph1_in;
         ph2_ff  <= ph2_in;
         done_ff <= done_in;
      end
      hold_ff <= hold_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

@@ rtl/mht_store.sv @@
// ----------------------------------------------------------------------------
// Mnemonic hash table slot store
// Simple dual-port slot memory with one write port, one read port and a registered read.
// ----------------------------------------------------------------------------
module mht_store #(
   parameter int TABLE_SIZE = mht_pkg::TABLE_SIZE_DEF
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(TABLE_SIZE)-1:0]  wr_addr,
   input  mht_pkg::slot_type              wr_slot,
   input  logic                           rd_en,
   input  logic [$clog2(TABLE_SIZE)-1:0]  rd_addr,
   output mht_pkg::slot_type              rd_slot
);
   import mht_pkg::*;

   slot_type slot_mem [TABLE_SIZE];
   slot_type rd_slot_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_slot_ff <= slot_mem[rd_addr];
      end
   end

   assign rd_slot = rd_slot_ff;

endmodule

@@ rtl/mnemonic_hash_table_unit.sv @@
// ----------------------------------------------------------------------------
// Mnemonic hash table unit
// Open-addressed name table with linear probing and a pipelined hash modulo unit.
// ----------------------------------------------------------------------------
// A request beat on the req_ channel carries an insert or a lookup of a name
// of up to three characters; every request yields exactly one rsp_ beat with
// the found value and a status. After reset the block sweeps the slot memory
// clear, all TABLE_SIZE slots, one slot a cycle, and holds req_stall high
// until the sweep ends. The block works on one request at a time and stalls
// the request channel while it does. After acceptance the modulo unit
// registers its product, remainder and result, and the sequencer takes the
// result into the slot register; each probe reads the memory in S_READ and
// compares the registered slot in S_CHECK, and S_RESP then loads the result
// register. A full table costs TABLE_SIZE probes. The next request is taken
// once the sequencer is back in idle after loading the result. An empty name
// skips the hash and the probes and goes straight to S_RESP. The result
// register parts the two sides, so a new request is taken while a result
// waits; when rsp_stall is held, the next result waits in the sequencer until
// the register frees.
// ----------------------------------------------------------------------------
module mnemonic_hash_table_unit #(
   parameter int TABLE_SIZE = mht_pkg::TABLE_SIZE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_type,
   input  logic [mht_pkg::CHAR_W-1:0]     req_key_char0,
   input  logic [mht_pkg::CHAR_W-1:0]     req_key_char1,
   input  logic [mht_pkg::CHAR_W-1:0]     req_key_char2,
   input  logic [mht_pkg::VALUE_W-1:0]    req_entry_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [mht_pkg::VALUE_W-1:0]    rsp_found_value,
   output logic [mht_pkg::STATUS_W-1:0]   rsp_status
);
   import mht_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int CNT_W = IDX_W + 1;
   localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(TABLE_SIZE - 1);
   localparam logic [CNT_W-1:0] LAST_PROBE = CNT_W'(TABLE_SIZE - 1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_HASH  = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [IDX_W-1:0]    clr_addr_ff, clr_addr_in;
   logic                op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [IDX_W-1:0]    slot_ff, slot_in;
   logic [CNT_W-1:0]    probe_ff, probe_in;
   logic [VALUE_W-1:0]  res_value_ff, res_value_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                req_accept;
   logic [CHAR_W-1:0]   char2_norm;
   logic [SUM_W-1:0]    hash_sum;
   logic                mod_start;
   logic                mod_done;
   logic [IDX_W-1:0]    mod_result;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   slot_type            wr_slot;
   logic                rd_en;
   slot_type            rd_slot;
   logic                out_free;
   logic [IDX_W-1:0]    slot_next;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign char2_norm = (req_key_char1 == '0) ? '0 : req_key_char2;
   assign hash_sum   = SUM_W'(req_key_char0) ^ (SUM_W'(req_key_char1) << 3)
                       ^ (SUM_W'(char2_norm) << 6);
   assign mod_start  = req_accept && (req_key_char0 != '0);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign slot_next  = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;

   mht_modred #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_modred (
      .clock  (clock),
      .reset  (reset),
      .start  (mod_start),
      .sum_in (hash_sum),
      .done   (mod_done),
      .result (mod_result)
   );

   mht_store #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_slot (wr_slot),
      .rd_en   (rd_en),
      .rd_addr (slot_ff),
      .rd_slot (rd_slot)
   );

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      slot_in       = slot_ff;
      probe_in      = probe_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = slot_ff;
      wr_slot       = '{key: key_ff, value: value_ff};
      rd_en         = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_slot     = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               op_in        = req_type;
               key_in       = {char2_norm, req_key_char1, req_key_char0};
               value_in     = req_entry_value;
               probe_in     = '0;
               res_value_in = '0;
               if (req_key_char0 == '0) begin
                  res_status_in = ST_EMPTY_NAME;
                  state_in      = S_RESP;
               end else begin
                  res_status_in = ST_OK;
                  state_in      = S_HASH;
               end
            end
         end
         S_HASH: begin
            if (mod_done) begin
               slot_in  = mod_result;
               state_in = S_READ;
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (op_ff == REQ_INSERT && rd_slot.key[CHAR_W-1:0] == '0) begin
               wr_en    = 1'b1;
               state_in = S_RESP;
            end else if (op_ff == REQ_LOOKUP && rd_slot.key == key_ff) begin
               res_value_in = rd_slot.value;
               state_in     = S_RESP;
            end else if (op_ff == REQ_LOOKUP && rd_slot.key[CHAR_W-1:0] == '0) begin
               res_status_in = ST_NOT_FOUND;
               state_in      = S_RESP;
            end else if (probe_ff == LAST_PROBE) begin
               res_status_in = (op_ff == REQ_INSERT) ? ST_FULL : ST_NOT_FOUND;
               state_in      = S_RESP;
            end else begin
               probe_in = probe_ff + 1'b1;
               slot_in  = slot_next;
               state_in = S_READ;
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      slot_ff       <= slot_in;
      probe_ff      <= probe_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found_value = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;

endmodule
